FILE: rtl/lbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link bring-up supervisor package
// Command, action, stage and register codes shared by the supervisor RTL.
// ----------------------------------------------------------------------------
package lbs_pkg;

  typedef enum logic [2:0] {
    CMD_POLL       = 3'd0,
    CMD_ASSOC_START = 3'd1,
    CMD_ASSOC_RES  = 3'd2,
    CMD_LOOKUP_RES = 3'd3,
    CMD_PREFLIGHT  = 3'd4,
    CMD_SESSION_RES = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_RECOVER = 3'd1,
    ACT_CONNECT = 3'd2,
    ACT_RESOLVE = 3'd3,
    ACT_TIMECFG = 3'd4,
    ACT_SESSION = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    ST_LINK    = 3'd0,
    ST_LOOKUP  = 3'd1,
    ST_TIME    = 3'd2,
    ST_SESSION = 3'd3,
    ST_ONLINE  = 3'd4
  } stage_t;

  typedef enum logic [2:0] {
    REG_INIT_RETRY = 3'd0,
    REG_MAX_RETRY  = 3'd1,
    REG_SYNC_TO    = 3'd2,
    REG_REC_THR    = 3'd3,
    REG_REC_COOL   = 3'd4,
    REG_ASSOC_TO   = 3'd5
  } reg_idx_t;

  localparam logic [31:0] INIT_RETRY_RST = 32'd1000;
  localparam logic [31:0] MAX_RETRY_RST  = 32'd60000;
  localparam logic [31:0] SYNC_TO_RST    = 32'd10000;
  localparam logic [15:0] REC_THR_RST    = 16'd3;
  localparam logic [31:0] REC_COOL_RST   = 32'd60000;
  localparam logic [31:0] ASSOC_TO_RST   = 32'd15000;

  // Deadline reached: wrapped difference now - deadline is not negative.
  function automatic logic reached(input logic [31:0] now, input logic [31:0] dl);
    logic [31:0] diff;
    diff = now - dl;
    return ~diff[31];
  endfunction

  // Backoff doubling, capped at the maximum delay.
  function automatic logic [31:0] grow(input logic [31:0] d, input logic [31:0] mx);
    logic [31:0] n;
    n = (d > {1'b0, mx[31:1]}) ? mx : {d[30:0], 1'b0};
    return (n < mx) ? n : mx;
  endfunction

endpackage

FILE: rtl/link_bringup_supervisor.sv
`timescale 1ns / 1ps
// Path: an accepted item is held in the input register, then the result
//   register is loaded together with the supervisor state and out_valid
//   rises; the result then waits there until taken.
// Throughput: one item per cycle; the state update is one registered pass.
//   The input stalls only while a result waits with out_ready low.
// Reset: synchronous active-low rst_n clears the control state, sets stage
//   to wait link, loads register defaults and both backoff delays to 1000 ms.
// ----------------------------------------------------------------------------
// Link bring-up supervisor
// Tracks bring-up stage, backoffs, deadlines, failures and forced recovery,
// and returns the action to issue with a status snapshot for every item.
// ----------------------------------------------------------------------------
module link_bringup_supervisor (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [31:0] in_now_ms,
  input  logic        in_link_up,
  input  logic        in_time_ok,
  input  logic        in_session_up,
  input  logic        in_success,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_action,
  output logic [2:0]  out_stage,
  output logic [31:0] out_retry_delay_ms,
  output logic [31:0] out_retry_at_ms,
  output logic        out_sync_in_flight,
  output logic        out_assoc_in_flight,
  output logic        out_confirm_pending,
  output logic [15:0] out_failure_count,
  output logic        out_cooldown_active,
  output logic [31:0] out_cooldown_until_ms,
  output logic        out_awaiting_drop,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lbs_pkg::*;

  // configuration registers
  logic [31:0] init_retry_r, max_retry_r, sync_to_r, rec_cool_r, assoc_to_r;
  logic [15:0] rec_thr_r;
  reg_idx_t    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_retry_r <= INIT_RETRY_RST;
      max_retry_r  <= MAX_RETRY_RST;
      sync_to_r    <= SYNC_TO_RST;
      rec_thr_r    <= REC_THR_RST;
      rec_cool_r   <= REC_COOL_RST;
      assoc_to_r   <= ASSOC_TO_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_INIT_RETRY: init_retry_r <= pwdata;
        REG_MAX_RETRY:  max_retry_r  <= pwdata;
        REG_SYNC_TO:    sync_to_r    <= pwdata;
        REG_REC_THR:    rec_thr_r    <= pwdata[15:0];
        REG_REC_COOL:   rec_cool_r   <= pwdata;
        REG_ASSOC_TO:   assoc_to_r   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_INIT_RETRY: prdata = init_retry_r;
      REG_MAX_RETRY:  prdata = max_retry_r;
      REG_SYNC_TO:    prdata = sync_to_r;
      REG_REC_THR:    prdata = {16'd0, rec_thr_r};
      REG_REC_COOL:   prdata = rec_cool_r;
      REG_ASSOC_TO:   prdata = assoc_to_r;
      default:        prdata = 32'd0;
    endcase
  end

  // input register
  logic        in_v_r;
  logic [2:0]  cmd_r;
  logic [31:0] now_r;
  logic        up_r, tok_r, sup_r, ok_r;
  logic        fire;

  // advance when the result register is free or being drained
  assign fire     = in_v_r && (!out_valid || out_ready);
  assign in_ready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd_r <= in_cmd;
      now_r <= in_now_ms;
      up_r  <= in_link_up;
      tok_r <= in_time_ok;
      sup_r <= in_session_up;
      ok_r  <= in_success;
    end
  end

  // supervisor state
  stage_t      stage_r, stage_nxt;
  logic [31:0] sdelay_r, sdelay_nxt, sdl_r, sdl_nxt;
  logic        issued_r, issued_nxt;
  logic [31:0] ldelay_r, ldelay_nxt, ldl_r, ldl_nxt;
  logic        abusy_r, abusy_nxt;
  logic [31:0] adl_r, adl_nxt;
  logic        cwait_r, cwait_nxt;
  logic [31:0] cdl_r, cdl_nxt;
  logic        sbusy_r, sbusy_nxt;
  logic [31:0] sydl_r, sydl_nxt;
  logic [15:0] fcnt_r, fcnt_nxt;
  logic        cool_r, cool_nxt;
  logic [31:0] cend_r, cend_nxt;
  logic        rpend_r, rpend_nxt;
  logic        dwait_r, dwait_nxt;
  action_t     act_nxt;

  logic        done;
  logic [15:0] thr, fcnt_inc;
  logic        fail;

  // next-state pass for one item
  always_comb begin
    stage_nxt  = stage_r;   sdelay_nxt = sdelay_r; sdl_nxt   = sdl_r;
    issued_nxt = issued_r;  ldelay_nxt = ldelay_r; ldl_nxt   = ldl_r;
    abusy_nxt  = abusy_r;   adl_nxt    = adl_r;    cwait_nxt = cwait_r;
    cdl_nxt    = cdl_r;     sbusy_nxt  = sbusy_r;  sydl_nxt  = sydl_r;
    fcnt_nxt   = fcnt_r;    cool_nxt   = cool_r;   cend_nxt  = cend_r;
    rpend_nxt  = rpend_r;   dwait_nxt  = dwait_r;
    act_nxt    = ACT_NONE;
    done       = 1'b0;
    fail       = 1'b0;
    thr        = (rec_thr_r == 16'd0) ? 16'd1 : rec_thr_r;
    fcnt_inc   = fcnt_r + 16'd1;

    case (cmd_t'(cmd_r))
      CMD_POLL: begin
        // forced recovery takes priority over everything
        if (rpend_r) begin
          rpend_nxt = 1'b0;
          stage_nxt = ST_LINK; sdelay_nxt = init_retry_r; sdl_nxt = now_r;
          issued_nxt = 1'b0; cwait_nxt = 1'b0;
          sbusy_nxt = 1'b0; abusy_nxt = 1'b0; ldl_nxt = now_r;
          dwait_nxt = 1'b1;
          act_nxt = ACT_RECOVER;
          done = 1'b1;
        end
        // hold until the link has actually dropped
        if (!done && dwait_nxt) begin
          if (up_r) done = 1'b1;
          else dwait_nxt = 1'b0;
        end
        if (!done && !up_r) begin
          if (stage_nxt != ST_LINK) begin
            stage_nxt = ST_LINK; sdelay_nxt = init_retry_r; sdl_nxt = now_r;
            issued_nxt = 1'b0; cwait_nxt = 1'b0;
            sbusy_nxt = 1'b0; abusy_nxt = 1'b0; ldl_nxt = now_r;
          end
          if (abusy_nxt && reached(now_r, adl_nxt)) begin
            abusy_nxt  = 1'b0;
            ldl_nxt    = now_r + ldelay_nxt;
            ldelay_nxt = grow(ldelay_nxt, max_retry_r);
          end
          if (abusy_nxt) done = 1'b1;
          if (!done && cwait_nxt) begin
            if (!reached(now_r, cdl_nxt)) begin
              done = 1'b1;
            end else begin
              cwait_nxt  = 1'b0;
              ldl_nxt    = now_r + ldelay_nxt;
              ldelay_nxt = grow(ldelay_nxt, max_retry_r);
            end
          end
          if (!done && reached(now_r, ldl_nxt)) begin
            abusy_nxt = 1'b1;
            adl_nxt   = now_r + assoc_to_r;
            act_nxt   = ACT_CONNECT;
          end
          done = 1'b1;
        end
        if (!done) begin
          if (stage_nxt == ST_LINK) begin
            stage_nxt = ST_LOOKUP; sdelay_nxt = init_retry_r; sdl_nxt = now_r;
            issued_nxt = 1'b0; cwait_nxt = 1'b0;
          end
          if (stage_nxt == ST_LOOKUP) begin
            if (!issued_nxt && reached(now_r, sdl_nxt)) begin
              issued_nxt = 1'b1;
              act_nxt = ACT_RESOLVE;
            end
            done = 1'b1;
          end
        end
        if (!done && stage_nxt == ST_TIME) begin
          if (tok_r) begin
            sbusy_nxt = 1'b0;
            stage_nxt = ST_SESSION; sdelay_nxt = init_retry_r; sdl_nxt = now_r;
            issued_nxt = 1'b0; cwait_nxt = 1'b0;
          end else begin
            if (sbusy_nxt && reached(now_r, sydl_nxt)) sbusy_nxt = 1'b0;
            // the backoff step re-opens the stage for the next attempt
            if (!sbusy_nxt && !issued_nxt && reached(now_r, sdl_nxt)) begin
              sdl_nxt    = now_r + sdelay_nxt;
              sdelay_nxt = grow(sdelay_nxt, max_retry_r);
              issued_nxt = 1'b0;
              sbusy_nxt  = 1'b1;
              sydl_nxt   = now_r + sync_to_r;
              act_nxt    = ACT_TIMECFG;
            end
            done = 1'b1;
          end
        end
        if (!done) begin
          if (stage_nxt == ST_SESSION) begin
            if (!tok_r) begin
              stage_nxt = ST_TIME; sdelay_nxt = init_retry_r; sdl_nxt = now_r;
              issued_nxt = 1'b0; cwait_nxt = 1'b0;
            end else if (sup_r) begin
              stage_nxt = ST_ONLINE; sdelay_nxt = init_retry_r; sdl_nxt = now_r;
              issued_nxt = 1'b0; cwait_nxt = 1'b0;
            end else if (!issued_nxt && reached(now_r, sdl_nxt)) begin
              issued_nxt = 1'b1;
              act_nxt = ACT_SESSION;
            end
          end else if (stage_nxt == ST_ONLINE && !sup_r) begin
            stage_nxt = tok_r ? ST_SESSION : ST_TIME;
            sdelay_nxt = init_retry_r; sdl_nxt = now_r;
            issued_nxt = 1'b0; cwait_nxt = 1'b0;
          end
        end
      end
      CMD_ASSOC_START: begin
        if (abusy_r) adl_nxt = now_r + assoc_to_r;
      end
      CMD_ASSOC_RES: begin
        if (stage_r == ST_LINK && abusy_r) begin
          abusy_nxt = 1'b0;
          if (ok_r) begin
            cwait_nxt = 1'b1;
            cdl_nxt   = now_r + assoc_to_r;
          end else begin
            ldl_nxt    = now_r + ldelay_r;
            ldelay_nxt = grow(ldelay_r, max_retry_r);
          end
        end
      end
      CMD_LOOKUP_RES: begin
        if (stage_r == ST_LOOKUP) begin
          if (ok_r) begin
            stage_nxt = ST_TIME; sdelay_nxt = init_retry_r; sdl_nxt = now_r;
            issued_nxt = 1'b0; cwait_nxt = 1'b0;
          end else begin
            sdl_nxt = now_r + sdelay_r; sdelay_nxt = grow(sdelay_r, max_retry_r);
            issued_nxt = 1'b0;
            fail = 1'b1;
          end
        end
      end
      CMD_PREFLIGHT: begin
        if (stage_r == ST_SESSION) begin
          stage_nxt = ST_LOOKUP; sdelay_nxt = init_retry_r; sdl_nxt = now_r;
          issued_nxt = 1'b0; cwait_nxt = 1'b0;
          fail = 1'b1;
        end
      end
      CMD_SESSION_RES: begin
        if (stage_r == ST_SESSION) begin
          if (ok_r) begin
            stage_nxt = ST_ONLINE; sdelay_nxt = init_retry_r; sdl_nxt = now_r;
            issued_nxt = 1'b0; cwait_nxt = 1'b0;
            fcnt_nxt = 16'd0; cool_nxt = 1'b0; rpend_nxt = 1'b0;
            dwait_nxt = 1'b0; ldelay_nxt = init_retry_r;
          end else begin
            sdl_nxt = now_r + sdelay_r; sdelay_nxt = grow(sdelay_r, max_retry_r);
            issued_nxt = 1'b0;
            fail = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // count a connectivity failure; arm forced recovery at the threshold unless in cooldown
    if (fail) begin
      if (fcnt_inc < thr) begin
        fcnt_nxt = fcnt_inc;
      end else begin
        fcnt_nxt = 16'd0;
        if (!(cool_r && !reached(now_r, cend_r))) begin
          cool_nxt  = 1'b1;
          cend_nxt  = now_r + rec_cool_r;
          rpend_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r  <= ST_LINK;
      sdelay_r <= INIT_RETRY_RST;
      sdl_r    <= 32'd0;
      issued_r <= 1'b0;
      ldelay_r <= INIT_RETRY_RST;
      ldl_r    <= 32'd0;
      abusy_r  <= 1'b0;
      adl_r    <= 32'd0;
      cwait_r  <= 1'b0;
      cdl_r    <= 32'd0;
      sbusy_r  <= 1'b0;
      sydl_r   <= 32'd0;
      fcnt_r   <= 16'd0;
      cool_r   <= 1'b0;
      cend_r   <= 32'd0;
      rpend_r  <= 1'b0;
      dwait_r  <= 1'b0;
    end else if (fire) begin
      stage_r  <= stage_nxt;
      sdelay_r <= sdelay_nxt;
      sdl_r    <= sdl_nxt;
      issued_r <= issued_nxt;
      ldelay_r <= ldelay_nxt;
      ldl_r    <= ldl_nxt;
      abusy_r  <= abusy_nxt;
      adl_r    <= adl_nxt;
      cwait_r  <= cwait_nxt;
      cdl_r    <= cdl_nxt;
      sbusy_r  <= sbusy_nxt;
      sydl_r   <= sydl_nxt;
      fcnt_r   <= fcnt_nxt;
      cool_r   <= cool_nxt;
      cend_r   <= cend_nxt;
      rpend_r  <= rpend_nxt;
      dwait_r  <= dwait_nxt;
    end
  end

  // result register: holds the item until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_action            <= act_nxt;
      out_stage             <= stage_nxt;
      out_retry_delay_ms    <= (stage_nxt == ST_LINK) ? ldelay_nxt : sdelay_nxt;
      out_retry_at_ms       <= (stage_nxt == ST_LINK) ? ldl_nxt : sdl_nxt;
      out_sync_in_flight    <= sbusy_nxt;
      out_assoc_in_flight   <= abusy_nxt;
      out_confirm_pending   <= cwait_nxt;
      out_failure_count     <= fcnt_nxt;
      out_cooldown_active   <= cool_nxt;
      out_cooldown_until_ms <= cend_nxt;
      out_awaiting_drop     <= dwait_nxt;
    end
  end

`ifndef ASSERT_OFF
  // confirmation wait only exists while waiting for link
  a_confirm_in_link: assert property (@(posedge clk) disable iff (!rst_n)
    cwait_r |-> stage_r == ST_LINK) else $error("confirm wait outside link stage");

  // a recovery result reports link stage and pending drop
  a_recover_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && act_nxt == ACT_RECOVER |=> out_stage == ST_LINK && out_awaiting_drop)
    else $error("recovery result inconsistent");

  // an empty result register never blocks the input side
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("input stalled with empty result register");

  // a consumed item always leaves new state and a new result
  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid) else $error("accepted item produced no result");
`endif

endmodule
